// File: sv/mts_pkg.sv
// shared constants and types for the min-tracking stack
package mts_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int OCC_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_top;
        logic load_out;
    } mts_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_load;
    } mts_stat_t;

endpackage

// File: sv/mts_ctrl.sv
// controller state machine for the min-tracking stack
module mts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t  cmd
);
    import mts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_full_reg;
    logic       out_full_next;
    logic       out_free;

    assign out_free = !out_full_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_full_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.need_load ? S_LOAD : S_DONE;
            end
            S_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output buffer occupancy
    always_comb
    begin
        priority if (cmd.load_out)
            out_full_next = 1'b1;
        else if (m_tready)
            out_full_next = 1'b0;
        else
            out_full_next = out_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

// File: sv/mts_dpath.sv
// datapath: occupancy, cached top minimum, prefix-minimum memory, result register
module mts_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         action,
    input  logic [mts_pkg::DATA_W-1:0]   value,
    input  mts_pkg::mts_cmd_t            cmd,
    output mts_pkg::mts_stat_t           stat,
    output logic [1:0]                   status,
    output logic [mts_pkg::DATA_W-1:0]   min_value,
    output logic                         min_valid
);
    import mts_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic              act_reg;
    logic [DATA_W-1:0] val_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] top_next;
    logic [1:0]        stat_reg;
    logic [1:0]        stat_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_min_reg;
    logic              out_valid_reg;

    logic              is_full;
    logic              is_empty;
    logic [DATA_W-1:0] new_min;
    logic              do_write;
    logic              do_read;
    logic [ADDR_W-1:0] rd_ptr;

    assign is_full  = (occ_reg == OCC_W'(STACK_DEPTH));
    assign is_empty = (occ_reg == '0);
    // entry below the top; wraps correctly from a full stack
    assign rd_ptr   = occ_reg[ADDR_W-1:0] - ADDR_W'(2);

    // smaller of the pushed value and the current top minimum
    assign new_min = (is_empty || ($signed(val_reg) < $signed(top_reg))) ? val_reg : top_reg;

    assign do_write       = cmd.exec && (act_reg == ACT_PUSH) && !is_full;
    assign do_read        = cmd.exec && (act_reg == ACT_POP) && (occ_reg > OCC_W'(1));
    assign stat.need_load = (act_reg == ACT_POP) && (occ_reg > OCC_W'(1));

    // occupancy, top and status update
    always_comb
    begin
        occ_next  = occ_reg;
        top_next  = top_reg;
        stat_next = stat_reg;
        if (cmd.exec)
        begin
            stat_next = ST_DONE;
            if (act_reg == ACT_PUSH)
            begin
                if (is_full)
                    stat_next = ST_FULL;
                else
                begin
                    occ_next = occ_reg + OCC_W'(1);
                    top_next = new_min;
                end
            end
            else
            begin
                if (is_empty)
                    stat_next = ST_EMPTY;
                else
                    occ_next = occ_reg - OCC_W'(1);
            end
        end
        else if (cmd.load_top)
        begin
            top_next = rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= action;
            val_reg <= value;
        end
        top_reg  <= top_next;
        stat_reg <= stat_next;
        if (cmd.load_out)
        begin
            out_status_reg <= stat_reg;
            out_min_reg    <= is_empty ? '0 : top_reg;
            out_valid_reg  <= !is_empty;
        end
    end

    // prefix-minimum memory
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[occ_reg[ADDR_W-1:0]] <= new_min;
        if (do_read)
            rdata_reg <= mem[rd_ptr];
    end

    assign status    = out_status_reg;
    assign min_value = out_min_reg;
    assign min_valid = out_valid_reg;

endmodule

// File: sv/min_tracking_stack.sv
// top level of the min-tracking stack
// A bounded stack of signed 32-bit values that reports the minimum of what it
// holds after every push or pop, one result per input transfer. The block works
// on one item at a time: a push, a refused push or a refused pop goes through
// the execute and done states, and a pop that leaves at least one value also
// goes through a load state that reloads the cached top minimum from the
// registered read of the prefix-minimum memory. A finished result waits in an
// output register, so the next item is taken while it is still unclaimed; that
// next item then holds in its done state until the waiting result is taken. No
// clearing pass follows reset; the stack is empty as soon as reset is released.
module min_tracking_stack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] min_value
    output logic [2:0]  m_tuser    // [1:0] status, [2] min_valid
);
    import mts_pkg::*;

    mts_cmd_t   cmd;
    mts_stat_t  stat;
    logic [1:0] status;
    logic       min_valid;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mts_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (s_tuser),
        .value     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .min_value (m_tdata),
        .min_valid (min_valid)
    );

    assign m_tuser = {min_valid, status};

endmodule

// File: sv/mts_checker.sv
// port-level checker for the min-tracking stack, with its bind
module mts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import mts_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // only defined status codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == ST_DONE || m_tuser[1:0] == ST_FULL
                      || m_tuser[1:0] == ST_EMPTY))
        else $error("undefined status code");

    // empty stack reports zero minimum
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata == '0)
        else $error("nonzero minimum on empty stack");

    // a refused push means the stack holds values
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_FULL |-> m_tuser[2])
        else $error("full refusal with empty stack");

    // a refused pop means the stack is empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_EMPTY |-> !m_tuser[2])
        else $error("empty refusal with valid minimum");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/min_tracking_stack_checker.sv
`timescale 1ns / 100ps
// result checker for the min-tracking stack: predicts each result and compares it
module min_tracking_stack_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] min_value
    input  logic [2:0]  m_tuser,   // [1:0] status, [2] min_valid
    output int          fail_count,
    output int          pending
);
    import mts_pkg::*;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] min_value;
        logic                     min_valid;
    } stack_outcome_t;

    // shadow of the stack: how many values are held and the prefix minima
    logic [OCC_W-1:0]         held_count;
    logic signed [DATA_W-1:0] prefix_min [STACK_DEPTH];
    stack_outcome_t           outcome_q [$];

    // apply one push or pop to the shadow stack and return the result it gives
    function automatic stack_outcome_t apply_stack_op(input logic act,
                                                      input logic signed [DATA_W-1:0] val);
        stack_outcome_t res;
        logic signed [DATA_W-1:0] new_min;
        res.status = ST_DONE;
        if (act == ACT_PUSH)
        begin
            if (held_count == STACK_DEPTH)
                res.status = ST_FULL;
            else
            begin
                // first value on an empty stack is its own minimum
                new_min = val;
                if (held_count != 0 && prefix_min[held_count - 1] < val)
                    new_min = prefix_min[held_count - 1];
                prefix_min[held_count] = new_min;
                held_count = held_count + 1'b1;
            end
        end
        else
        begin
            if (held_count == 0)
                res.status = ST_EMPTY;
            else
                held_count = held_count - 1'b1;
        end
        res.min_valid = (held_count != 0);
        res.min_value = '0;
        if (held_count != 0)
            res.min_value = prefix_min[held_count - 1];
        return res;
    endfunction

    // compare each result transfer, then predict from each input transfer
    always @(posedge clk or negedge rst_n)
    begin : track
        stack_outcome_t want;
        if (!rst_n)
        begin
            held_count = '0;
            outcome_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d min %0d valid %0d",
                             $time, m_tuser[1:0], $signed(m_tdata), m_tuser[2]);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tuser[1:0] !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tuser[1:0]);
                        fail_count++;
                    end
                    if ($signed(m_tdata) !== want.min_value)
                    begin
                        $display("%0t: min_value mismatch: expected %0d, got %0d",
                                 $time, want.min_value, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[2] !== want.min_valid)
                    begin
                        $display("%0t: min_valid mismatch: expected %0d, got %0d",
                                 $time, want.min_valid, m_tuser[2]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_stack_op(s_tuser, $signed(s_tdata)));
            pending = outcome_q.size();
        end
    end

endmodule

// File: tb/min_tracking_stack_tb.sv
`timescale 1ns / 100ps
// testbench top for the min-tracking stack: stimulus, stalls, watchdog and verdict
module min_tracking_stack_tb;
    import mts_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_EVERY  = 400;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;

    int          burst_left;
    logic [31:0] last_pushed;

    min_tracking_stack DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    min_tracking_stack_checker stack_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one input transfer, then the end of a burst may bring a gap
    task automatic send_op(input logic act, input logic [31:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // hold off the sender until every predicted result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // push data: full range, clustered small values for ties, extremes, repeats
    function automatic logic [31:0] pick_push_value();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 15) - 8;
            7:             return 32'h7FFF_FFFF;
            8:             return 32'h8000_0000;
            default:       return last_pushed;
        endcase
    endfunction

    // receiver stalls: modes that change after a random hold
    initial
    begin : stall_pattern
        rx_mode_t mode;
        int       hold;
        int       period;
        int       low_len;
        int       phase;
        m_tready = 1'b0;
        forever
        begin
            mode    = rx_mode_t'($urandom_range(0, 3));
            hold    = $urandom_range(40, 300);
            period  = $urandom_range(2, 8);
            low_len = $urandom_range(1, period - 1);
            for (phase = 0; phase < hold; phase++)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_tready <= ((phase % period) >= low_len);
                    default:     m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // reset, directed sequence, random sequence, verdict
    initial
    begin : stimulus
        int i;
        int seg_left;
        int push_pct;
        logic [31:0] val;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = ACT_PUSH;
        s_tdata     = '0;
        burst_left  = 0;
        last_pushed = '0;
        seg_left    = 0;
        push_pct    = 50;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pop on empty, first push, tie, both extremes
        send_op(ACT_POP, 32'hFFFF_FFFF);
        send_op(ACT_PUSH, 32'd5);
        send_op(ACT_PUSH, 32'd5);
        send_op(ACT_PUSH, 32'h7FFF_FFFF);
        send_op(ACT_PUSH, 32'h8000_0000);
        send_op(ACT_POP, 32'h0000_0000);
        // fill to the top with a falling minimum
        for (i = 0; i < 13; i++)
            send_op(ACT_PUSH, 32'd0 - i * 3);
        // push on full, then churn at the top
        send_op(ACT_PUSH, 32'h8000_0000);
        send_op(ACT_POP, 32'h5555_5555);
        send_op(ACT_PUSH, 32'h8000_0000);
        send_op(ACT_POP, 32'hAAAA_AAAA);
        send_op(ACT_POP, 32'h0000_0000);
        drain_results();

        // random segments biased toward filling, emptying or churning
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 10;
                    1:       push_pct = 50;
                    default: push_pct = 90;
                endcase
            end
            seg_left--;
            if ($urandom_range(1, 100) <= push_pct)
            begin
                val = pick_push_value();
                last_pushed = val;
                send_op(ACT_PUSH, val);
            end
            else
                send_op(ACT_POP, $urandom);
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/mts_pkg.sv
sv/mts_ctrl.sv
sv/mts_dpath.sv
sv/min_tracking_stack.sv
sv/mts_checker.sv
tb/min_tracking_stack_checker.sv
tb/min_tracking_stack_tb.sv
